FILE: rtl/core/csem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csem_pkg
// Shared codes, field widths and defaults of the counting semaphore table.
// ----------------------------------------------------------------------------
package csem_pkg;

   localparam int unsigned NUM_SEMAPHORES_DEF = 16;
   localparam int unsigned WAIT_DEPTH_DEF     = 16;
   localparam int unsigned PID_BITS_DEF       = 8;
   localparam int unsigned COUNT_BITS_DEF     = 16;

   localparam int unsigned COMMAND_W    = 3;
   localparam int unsigned SEM_INDEX_W  = 4;
   localparam int unsigned PID_PORT_W   = 8;
   localparam int unsigned INIT_COUNT_W = 16;
   localparam int unsigned BLOCKED_W    = 5;

   typedef enum logic [COMMAND_W-1:0] {
      CMD_INIT     = 3'd0,
      CMD_WAIT     = 3'd1,
      CMD_POST     = 3'd2,
      CMD_DESTROY  = 3'd3,
      CMD_WAKE_ALL = 3'd4,
      CMD_QUERY    = 3'd5
   } command_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_SEM     = 2'd1,
      ST_QUEUE_FULL = 2'd2,
      ST_SATURATED  = 2'd3
   } status_type;

   typedef struct packed {
      status_type             status;
      logic                   must_block;
      logic                   wake_valid;
      logic [PID_PORT_W-1:0]  wake_pid;
      logic [BLOCKED_W-1:0]   blocked;
      logic                   existed;
      logic                   last;
   } result_type;

endpackage : csem_pkg
`default_nettype wire

FILE: rtl/core/csem_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csem_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data (data holds between reads).
// ----------------------------------------------------------------------------
module csem_ram #(
   parameter  int unsigned WIDTH  = 8,
   parameter  int unsigned DEPTH  = 16,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : csem_ram
`default_nettype wire

FILE: rtl/core/counting_semaphore_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_table
// Table of counting semaphores, each with a count and a FIFO of waiting
// process ids. Count, queue head and occupancy live in a metadata RAM, the
// waiters in a wait RAM; valid bits are flip-flops.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_stall  | command, sem_index, requester_pid,
//           |     |                      | init_count
//   rsp     | out | rsp_valid/rsp_stall  | status, caller_must_block,
//           |     |                      | wake_valid, wake_pid, blocked_count,
//           |     |                      | already_existed, last
//
// A request with one result is accepted with a metadata read, then evaluated
// and written back. Destroy and wake_all with N waiters do one wait RAM read
// per woken waiter; a post that wakes reads one waiter.
// Reset clears the valid bits; no clearing pass of the RAMs.
// Results sit in an output register, so the next request is taken while the
// previous result is stalled; a stalled result stalls evaluation and dequeue.
// ----------------------------------------------------------------------------
module counting_semaphore_table
   import csem_pkg::*;
#(
   parameter int unsigned NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
   parameter int unsigned WAIT_DEPTH     = WAIT_DEPTH_DEF,
   parameter int unsigned PID_BITS       = PID_BITS_DEF,
   parameter int unsigned COUNT_BITS     = COUNT_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire logic [COMMAND_W-1:0]    req_command,
   input  wire logic [SEM_INDEX_W-1:0]  req_sem_index,
   input  wire logic [PID_PORT_W-1:0]   req_requester_pid,
   input  wire logic [INIT_COUNT_W-1:0] req_init_count,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      logic [1:0]              rsp_status,
   output      logic                    rsp_caller_must_block,
   output      logic                    rsp_wake_valid,
   output      logic [PID_PORT_W-1:0]   rsp_wake_pid,
   output      logic [BLOCKED_W-1:0]    rsp_blocked_count,
   output      logic                    rsp_already_existed,
   output      logic                    rsp_last
);

   localparam int unsigned IDX_W   = $clog2(NUM_SEMAPHORES);
   localparam int unsigned HEAD_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int unsigned OCC_W   = $clog2(WAIT_DEPTH + 1);
   localparam int unsigned SUM_W   = OCC_W + 1;
   localparam int unsigned META_W  = COUNT_BITS + HEAD_W + OCC_W;
   localparam int unsigned STORE_D = NUM_SEMAPHORES * WAIT_DEPTH;
   localparam int unsigned SADDR_W = $clog2(STORE_D);
   localparam logic [32:0] COUNT_MAX_W = (33'd1 << COUNT_BITS) - 33'd1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_POP
   } state_type;

   state_type               state_ff;
   command_type             cmd_ff;
   logic [SEM_INDEX_W-1:0]  idx_ff;
   logic                    in_range_ff;
   logic [PID_BITS-1:0]     pid_ff;
   logic [INIT_COUNT_W-1:0] icnt_ff;
   logic [NUM_SEMAPHORES-1:0] valid_ff;
   logic [COUNT_BITS-1:0]   count_ff;
   logic [HEAD_W-1:0]       head_ff;
   logic [OCC_W-1:0]        occ_ff;
   logic                    rsp_valid_ff;
   result_type              rsp_ff;

   logic                    req_accept;
   logic                    req_in_range;
   logic                    out_free;
   logic                    rsp_load;
   logic [IDX_W-1:0]        sidx;
   logic                    sem_valid;

   // metadata RAM
   logic                    meta_we;
   logic [META_W-1:0]       meta_wdata;
   logic                    meta_rd_en;
   logic [META_W-1:0]       meta_rd_data;
   logic [COUNT_BITS-1:0]   m_count;
   logic [HEAD_W-1:0]       m_head;
   logic [OCC_W-1:0]        m_occ;

   // wait RAM
   logic                    store_we;
   logic [SADDR_W-1:0]      store_waddr;
   logic                    store_rd_en;
   logic [SADDR_W-1:0]      store_raddr;
   logic [PID_BITS-1:0]     store_rd_data;
   logic [SADDR_W-1:0]      store_base;

   // evaluation
   result_type              eval_res;
   logic                    eval_pop;
   logic                    eval_meta_we;
   logic [META_W-1:0]       eval_meta_wdata;
   logic                    eval_set_valid;
   logic                    eval_clr_valid;
   logic                    eval_store_we;
   logic                    eval_fire;
   logic                    init_sat;
   logic [COUNT_BITS-1:0]   init_cnt;
   logic [SUM_W-1:0]        slot_sum;
   logic [HEAD_W-1:0]       slot;

   // dequeue
   result_type              pop_res;
   logic [OCC_W-1:0]        pop_occ;
   logic [HEAD_W-1:0]       pop_head;
   logic                    pop_last;
   logic                    pop_fire;

   assign req_stall    = (state_ff != S_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign req_in_range = (32'(req_sem_index) < NUM_SEMAPHORES);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   assign sidx      = IDX_W'(idx_ff);
   assign sem_valid = in_range_ff && valid_ff[sidx];

   assign m_count = meta_rd_data[META_W-1 -: COUNT_BITS];
   assign m_head  = meta_rd_data[OCC_W +: HEAD_W];
   assign m_occ   = meta_rd_data[OCC_W-1:0];

   assign store_base = SADDR_W'(32'(sidx) * 32'(WAIT_DEPTH));

   assign init_sat = ({17'd0, icnt_ff} > COUNT_MAX_W);
   assign init_cnt = init_sat ? {COUNT_BITS{1'b1}} : COUNT_BITS'(icnt_ff);

   // tail slot of the circular queue
   assign slot_sum = SUM_W'(m_head) + SUM_W'(m_occ);
   assign slot = (slot_sum >= SUM_W'(WAIT_DEPTH)) ?
                 HEAD_W'(slot_sum - SUM_W'(WAIT_DEPTH)) : HEAD_W'(slot_sum);

   always_comb begin
      eval_res        = '0;
      eval_res.last   = 1'b1;
      eval_pop        = 1'b0;
      eval_meta_we    = 1'b0;
      eval_meta_wdata = meta_rd_data;
      eval_set_valid  = 1'b0;
      eval_clr_valid  = 1'b0;
      eval_store_we   = 1'b0;
      priority if (cmd_ff > CMD_QUERY) begin
         // unknown command: all-zero result but for last, which is set
      end else if (!in_range_ff) begin
         eval_res.status = ST_NO_SEM;
      end else if (cmd_ff == CMD_INIT) begin
         if (sem_valid) begin
            eval_res.blocked = BLOCKED_W'(m_occ);
            eval_res.existed = 1'b1;
         end else begin
            eval_set_valid  = 1'b1;
            eval_meta_we    = 1'b1;
            eval_meta_wdata = {init_cnt, {HEAD_W{1'b0}}, {OCC_W{1'b0}}};
            if (init_sat) begin
               eval_res.status = ST_SATURATED;
            end
         end
      end else if (!sem_valid) begin
         eval_res.status = ST_NO_SEM;
      end else begin
         unique case (cmd_ff)
            CMD_WAIT: begin
               if (m_count != '0) begin
                  eval_meta_we     = 1'b1;
                  eval_meta_wdata  = {m_count - COUNT_BITS'(1), m_head, m_occ};
                  eval_res.blocked = BLOCKED_W'(m_occ);
               end else if (m_occ == OCC_W'(WAIT_DEPTH)) begin
                  eval_res.status  = ST_QUEUE_FULL;
                  eval_res.blocked = BLOCKED_W'(m_occ);
               end else begin
                  eval_store_we       = 1'b1;
                  eval_meta_we        = 1'b1;
                  eval_meta_wdata     = {m_count, m_head, m_occ + OCC_W'(1)};
                  eval_res.must_block = 1'b1;
                  eval_res.blocked    = BLOCKED_W'(m_occ + OCC_W'(1));
               end
            end
            CMD_POST: begin
               if (m_occ != '0) begin
                  eval_pop = 1'b1;
               end else if (m_count == {COUNT_BITS{1'b1}}) begin
                  eval_res.status = ST_SATURATED;
               end else begin
                  eval_meta_we    = 1'b1;
                  eval_meta_wdata = {m_count + COUNT_BITS'(1), m_head, m_occ};
               end
            end
            CMD_DESTROY, CMD_WAKE_ALL: begin
               if (m_occ != '0) begin
                  eval_pop = 1'b1;
               end else begin
                  eval_clr_valid = (cmd_ff == CMD_DESTROY);
               end
            end
            default: begin
               eval_res.blocked = BLOCKED_W'(m_occ);
            end
         endcase
      end
   end

   assign eval_fire = (state_ff == S_EVAL) && !eval_pop && out_free;

   assign pop_occ  = occ_ff - OCC_W'(1);
   assign pop_head = (head_ff == HEAD_W'(WAIT_DEPTH - 1)) ? '0 : head_ff + HEAD_W'(1);
   assign pop_last = (cmd_ff == CMD_POST) || (pop_occ == '0);
   assign pop_fire = (state_ff == S_POP) && out_free;

   assign rsp_load = eval_fire || pop_fire;

   always_comb begin
      pop_res            = '0;
      pop_res.wake_valid = 1'b1;
      pop_res.wake_pid   = PID_PORT_W'(store_rd_data);
      pop_res.blocked    = BLOCKED_W'(pop_occ);
      pop_res.last       = pop_last;
   end

   assign meta_rd_en = req_accept && req_in_range;
   assign meta_we    = (eval_fire && eval_meta_we) ||
                       (pop_fire && pop_last && (cmd_ff != CMD_DESTROY));
   assign meta_wdata = (state_ff == S_POP) ? {count_ff, pop_head, pop_occ} :
                       eval_meta_wdata;

   assign store_we    = eval_fire && eval_store_we;
   assign store_waddr = store_base + SADDR_W'(slot);
   assign store_rd_en = ((state_ff == S_EVAL) && eval_pop) || (pop_fire && !pop_last);
   assign store_raddr = (state_ff == S_POP) ? store_base + SADDR_W'(pop_head) :
                        store_base + SADDR_W'(m_head);

   csem_ram #(
      .WIDTH (META_W),
      .DEPTH (NUM_SEMAPHORES)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (sidx),
      .wr_data (meta_wdata),
      .rd_en   (meta_rd_en),
      .rd_addr (IDX_W'(req_sem_index)),
      .rd_data (meta_rd_data)
   );

   csem_ram #(
      .WIDTH (PID_BITS),
      .DEPTH (STORE_D)
   ) u_wait_ram (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_waddr),
      .wr_data (pid_ff),
      .rd_en   (store_rd_en),
      .rd_addr (store_raddr),
      .rd_data (store_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff      <= command_type'(req_command);
                  idx_ff      <= req_sem_index;
                  in_range_ff <= req_in_range;
                  pid_ff      <= PID_BITS'(req_requester_pid);
                  icnt_ff     <= req_init_count;
                  state_ff    <= S_EVAL;
               end
            end
            S_EVAL: begin
               if (eval_pop) begin
                  count_ff <= m_count;
                  head_ff  <= m_head;
                  occ_ff   <= m_occ;
                  state_ff <= S_POP;
               end else if (out_free) begin
                  rsp_ff <= eval_res;
                  if (eval_set_valid) begin
                     valid_ff[sidx] <= 1'b1;
                  end
                  if (eval_clr_valid) begin
                     valid_ff[sidx] <= 1'b0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            S_POP: begin
               if (out_free) begin
                  rsp_ff  <= pop_res;
                  head_ff <= pop_head;
                  occ_ff  <= pop_occ;
                  if (pop_last) begin
                     // on destroy, drop the semaphore once its last waiter is out
                     if (cmd_ff == CMD_DESTROY) begin
                        valid_ff[sidx] <= 1'b0;
                     end
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_ff.status;
   assign rsp_caller_must_block = rsp_ff.must_block;
   assign rsp_wake_valid        = rsp_ff.wake_valid;
   assign rsp_wake_pid          = rsp_ff.wake_pid;
   assign rsp_blocked_count     = rsp_ff.blocked;
   assign rsp_already_existed   = rsp_ff.existed;
   assign rsp_last              = rsp_ff.last;

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_EVAL))
      else $error("accepted transaction did not move to evaluation");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> (occ_ff != '0))
      else $error("dequeue from an empty wait queue");

   a_meta_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(meta_we && meta_rd_en))
      else $error("metadata read and write in the same cycle");

   a_block_xor_wake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.must_block && rsp_ff.wake_valid))
      else $error("result both blocks the caller and wakes a waiter");

endmodule : counting_semaphore_table
`default_nettype wire
